FILE: rtl/core/gpool_pkg.sv
// Shared types and constants of the global pooling block.
// Used by every module under rtl/core; depends on nothing else.
`timescale 1ns / 1ps

package gpool_pkg;

  // Defaults for the top-level parameters.
  localparam int unsigned SAMPLE_WIDTH_DEF = 8;
  localparam int unsigned MAX_CHANNELS_DEF = 64;
  localparam int unsigned ACC_WIDTH_DEF    = 16;

  // Fixed field widths.
  localparam int unsigned POOLED_W   = 16;
  localparam int unsigned CH_IDX_W   = 6;
  localparam int unsigned M_TDATA_W  = 24;
  localparam int unsigned COUNT_W    = 7;
  localparam int unsigned WIN_W      = 16;
  localparam int unsigned MARGIN_W   = 4;
  localparam int unsigned EXP_W      = 6;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_POOL_MODE        = 2'd0,
    CFG_CHANNEL_COUNT    = 2'd1,
    CFG_WINDOW_POSITIONS = 2'd2,
    CFG_MARGIN_BITS      = 2'd3
  } cfg_idx_e;

  typedef enum logic {
    MODE_MAX = 1'b0,
    MODE_AVG = 1'b1
  } pool_mode_e;

  // Configuration as seen by the datapath.
  typedef struct packed {
    pool_mode_e         mode;
    logic [COUNT_W-1:0] count;    // raw channel count, clamped downstream
    logic [WIN_W-1:0]   win_eff;  // window with zero read as one
    logic [EXP_W-1:0]   sat_exp;  // saturation bound is 2^sat_exp
  } cfg_t;

  // Label that travels with each pooled result.
  typedef struct packed {
    logic [CH_IDX_W-1:0] channel_index;
    logic                last_channel;
  } tag_t;

endpackage

FILE: rtl/core/global_pool_max_or_avg.sv
// Path, without back-pressure: a max-mode result passes the accumulator's second stage and
// the output register; in average mode the iterative divider, as wide as the wider of
// ACC_WIDTH and SAMPLE_WIDTH, sits between the second stage and the output register.
// Throughput: one sample per cycle, except at a window's last position, where the input waits
// for a free output register and, in average mode, for the divider to finish each channel.
// Reset clears configuration and counters; the accumulator memory is not
// cleared, the entry of each channel in use is rewritten at the first position of a window.
`timescale 1ns / 1ps

module global_pool_max_or_avg #(
  parameter int unsigned SAMPLE_WIDTH = gpool_pkg::SAMPLE_WIDTH_DEF,
  parameter int unsigned MAX_CHANNELS = gpool_pkg::MAX_CHANNELS_DEF,
  parameter int unsigned ACC_WIDTH    = gpool_pkg::ACC_WIDTH_DEF
) (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    cfg_we_i,
  input  logic [gpool_pkg::CFG_IDX_W-1:0]         cfg_idx_i,
  input  logic [gpool_pkg::CFG_DATA_W-1:0]        cfg_wdata_i,
  input  logic                                    s_axis_tvalid,
  output logic                                    s_axis_tready,
  // sample
  input  logic [((SAMPLE_WIDTH+7)/8)*8-1:0]       s_axis_tdata,
  output logic                                    m_axis_tvalid,
  input  logic                                    m_axis_tready,
  // pooled_value [15:0], channel_index [21:16], zero pad [23:22]
  output logic [gpool_pkg::M_TDATA_W-1:0]         m_axis_tdata,
  output logic                                    m_axis_tlast
);
  import gpool_pkg::*;

  localparam int unsigned STORE_W = (ACC_WIDTH > SAMPLE_WIDTH) ? ACC_WIDTH : SAMPLE_WIDTH;

  cfg_t                      cfg;
  logic                      sink_ready;
  logic                      emit_valid;
  logic                      emit_avg;
  logic signed [STORE_W-1:0] emit_value;
  tag_t                      emit_tag;
  logic                      div_start;
  logic                      div_busy;
  logic                      div_done;
  logic                      div_take;
  logic signed [STORE_W-1:0] div_quot;
  tag_t                      div_tag;
  logic                      out_free;
  logic                      load_max;

  logic                      out_valid_q;
  logic [POOLED_W-1:0]       out_pooled_q;
  logic [CH_IDX_W-1:0]       out_ch_q;
  logic                      out_last_q;

  gpool_cfg #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH),
    .ACC_WIDTH    (ACC_WIDTH)
  ) u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  gpool_acc #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH),
    .MAX_CHANNELS (MAX_CHANNELS),
    .ACC_WIDTH    (ACC_WIDTH),
    .STORE_W      (STORE_W)
  ) u_acc (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .in_sample_i  ($signed(s_axis_tdata[SAMPLE_WIDTH-1:0])),
    .sink_ready_i (sink_ready),
    .emit_valid_o (emit_valid),
    .emit_avg_o   (emit_avg),
    .emit_value_o (emit_value),
    .emit_tag_o   (emit_tag)
  );

  gpool_div #(
    .DATA_W (STORE_W)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (emit_value),
    .divisor_i  (cfg.win_eff),
    .tag_i      (emit_tag),
    .busy_o     (div_busy),
    .done_o     (div_done),
    .take_i     (div_take),
    .quotient_o (div_quot),
    .tag_o      (div_tag)
  );

  // A result is only released from the accumulator when it has somewhere to go.
  assign out_free   = !out_valid_q || m_axis_tready;
  assign sink_ready = !div_busy && out_free;
  assign load_max   = emit_valid && !emit_avg;
  assign div_start  = emit_valid && emit_avg;
  assign div_take   = div_done && out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_max || div_take) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_max) begin
      out_pooled_q <= POOLED_W'(emit_value);
      out_ch_q     <= emit_tag.channel_index;
      out_last_q   <= emit_tag.last_channel;
    end else if (div_take) begin
      out_pooled_q <= POOLED_W'(div_quot);
      out_ch_q     <= div_tag.channel_index;
      out_last_q   <= div_tag.last_channel;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {(M_TDATA_W - POOLED_W - CH_IDX_W)'(0), out_ch_q, out_pooled_q};
  assign m_axis_tlast  = out_last_q;

endmodule

FILE: rtl/core/gpool_cfg.sv
// Configuration registers of the global pooling block.
// Depends on gpool_pkg.
`timescale 1ns / 1ps

module gpool_cfg #(
  parameter int unsigned SAMPLE_WIDTH = gpool_pkg::SAMPLE_WIDTH_DEF,
  parameter int unsigned ACC_WIDTH    = gpool_pkg::ACC_WIDTH_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [gpool_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [gpool_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  output gpool_pkg::cfg_t                  cfg_o
);
  import gpool_pkg::*;

  pool_mode_e          mode_q;
  logic [COUNT_W-1:0]  count_q;
  logic [WIN_W-1:0]    win_q;
  logic [MARGIN_W-1:0] margin_q;
  logic [EXP_W-1:0]    exp_raw;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= MODE_MAX;
      count_q  <= COUNT_W'(1);
      win_q    <= WIN_W'(1);
      margin_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_POOL_MODE:        mode_q   <= pool_mode_e'(cfg_wdata_i[0]);
        CFG_CHANNEL_COUNT:    count_q  <= cfg_wdata_i[COUNT_W-1:0];
        CFG_WINDOW_POSITIONS: win_q    <= cfg_wdata_i[WIN_W-1:0];
        CFG_MARGIN_BITS:      margin_q <= cfg_wdata_i[MARGIN_W-1:0];
        default: ;
      endcase
    end
  end

  // The sum bound grows with the margin but never past the accumulator width.
  assign exp_raw = EXP_W'(SAMPLE_WIDTH - 1) + EXP_W'(margin_q);

  always_comb begin
    cfg_o.mode    = mode_q;
    cfg_o.count   = count_q;
    cfg_o.win_eff = (win_q == '0) ? WIN_W'(1) : win_q;
    cfg_o.sat_exp = (exp_raw > EXP_W'(ACC_WIDTH - 1)) ? EXP_W'(ACC_WIDTH - 1) : exp_raw;
  end

endmodule

FILE: rtl/core/gpool_acc.sv
// Per-channel accumulator memory with a read-modify-write pipeline and the
// channel and position counters. Depends on gpool_pkg.
`timescale 1ns / 1ps

module gpool_acc #(
  parameter int unsigned SAMPLE_WIDTH = gpool_pkg::SAMPLE_WIDTH_DEF,
  parameter int unsigned MAX_CHANNELS = gpool_pkg::MAX_CHANNELS_DEF,
  parameter int unsigned ACC_WIDTH    = gpool_pkg::ACC_WIDTH_DEF,
  parameter int unsigned STORE_W      = (ACC_WIDTH > SAMPLE_WIDTH) ? ACC_WIDTH : SAMPLE_WIDTH
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  gpool_pkg::cfg_t                cfg_i,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic signed [SAMPLE_WIDTH-1:0] in_sample_i,
  input  logic                           sink_ready_i,
  output logic                           emit_valid_o,
  output logic                           emit_avg_o,
  output logic signed [STORE_W-1:0]      emit_value_o,
  output gpool_pkg::tag_t                emit_tag_o
);
  import gpool_pkg::*;

  localparam int unsigned CHW   = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int unsigned CLGW  = $clog2(MAX_CHANNELS + 1);
  localparam int unsigned CNT_W = (CLGW > COUNT_W) ? CLGW : COUNT_W;

  logic signed [STORE_W-1:0] mem [MAX_CHANNELS];

  logic [CHW-1:0]   ch_q;
  logic [WIN_W-1:0] pos_q;

  // Second stage: the item whose stored value is being read back.
  logic                           b_valid_q;
  logic [CHW-1:0]                 b_ch_q;
  logic                           b_first_q;
  logic                           b_last_pos_q;
  logic                           b_last_ch_q;
  logic signed [SAMPLE_WIDTH-1:0] b_x_q;
  logic signed [STORE_W-1:0]      rd_q;
  logic                           fwd_q;
  logic signed [STORE_W-1:0]      fwd_data_q;

  logic [CNT_W-1:0]          cnt_raw;
  logic [CNT_W-1:0]          cnt_eff;
  logic [CHW-1:0]            ch_cur;
  logic                      first_pos;
  logic                      last_pos;
  logic                      last_ch;
  logic                      accept;
  logic                      b_fire;
  logic signed [STORE_W-1:0] base;
  logic signed [STORE_W-1:0] x_ext;
  logic signed [STORE_W:0]   sum;
  logic [STORE_W:0]          pow;
  logic signed [STORE_W:0]   hi;
  logic signed [STORE_W:0]   lo;
  logic signed [STORE_W-1:0] new_acc;

  // Stage A: channel and position bookkeeping for the incoming beat.
  always_comb begin
    cnt_raw = CNT_W'(cfg_i.count);
    if (cnt_raw == '0) begin
      cnt_eff = CNT_W'(1);
    end else if (cnt_raw > CNT_W'(MAX_CHANNELS)) begin
      cnt_eff = CNT_W'(MAX_CHANNELS);
    end else begin
      cnt_eff = cnt_raw;
    end
    ch_cur    = (CNT_W'(ch_q) >= cnt_eff) ? '0 : ch_q;
    first_pos = (pos_q == '0);
    last_pos  = (pos_q >= (cfg_i.win_eff - WIN_W'(1)));
    last_ch   = (CNT_W'(ch_cur) >= (cnt_eff - CNT_W'(1)));
  end

  // Stage B moves on unless it carries a result that the sink cannot take.
  assign b_fire     = b_valid_q && (!b_last_pos_q || sink_ready_i);
  assign in_ready_o = !b_valid_q || b_fire;
  assign accept     = in_valid_i && in_ready_o;

  // Stage B: combine the stored value with the sample.
  always_comb begin
    base  = b_first_q ? '0 : (fwd_q ? fwd_data_q : rd_q);
    x_ext = STORE_W'(b_x_q);
    sum   = (STORE_W+1)'(base) + (STORE_W+1)'(x_ext);
    pow   = (STORE_W+1)'(1) << cfg_i.sat_exp;
    hi    = $signed(pow - (STORE_W+1)'(1));
    lo    = -$signed(pow);
    if (cfg_i.mode == MODE_MAX) begin
      new_acc = (b_first_q || (x_ext > base)) ? x_ext : base;
    end else if (sum > hi) begin
      new_acc = STORE_W'(hi);
    end else if (sum < lo) begin
      new_acc = STORE_W'(lo);
    end else begin
      new_acc = STORE_W'(sum);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ch_q      <= '0;
      pos_q     <= '0;
      b_valid_q <= 1'b0;
      fwd_q     <= 1'b0;
    end else begin
      if (accept) begin
        b_valid_q <= 1'b1;
        // A write-back to the entry being read this edge is forwarded.
        fwd_q     <= b_fire && (b_ch_q == ch_cur);
        if (last_ch) begin
          ch_q  <= '0;
          pos_q <= last_pos ? '0 : (pos_q + WIN_W'(1));
        end else begin
          ch_q <= ch_cur + CHW'(1);
        end
      end else if (b_fire) begin
        b_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      b_ch_q       <= ch_cur;
      b_first_q    <= first_pos;
      b_last_pos_q <= last_pos;
      b_last_ch_q  <= last_ch;
      b_x_q        <= in_sample_i;
      rd_q         <= mem[ch_cur];
      fwd_data_q   <= new_acc;
    end
  end

  always_ff @(posedge clk_i) begin
    if (b_fire) begin
      mem[b_ch_q] <= new_acc;
    end
  end

  assign emit_valid_o             = b_fire && b_last_pos_q;
  assign emit_avg_o               = (cfg_i.mode == MODE_AVG);
  assign emit_value_o             = new_acc;
  assign emit_tag_o.channel_index = CH_IDX_W'(b_ch_q);
  assign emit_tag_o.last_channel  = b_last_ch_q;

endmodule

FILE: rtl/core/gpool_div.sv
// Iterative signed-by-unsigned divider, one quotient bit per cycle,
// truncating toward zero. Depends on gpool_pkg.
`timescale 1ns / 1ps

module gpool_div #(
  parameter int unsigned DATA_W = gpool_pkg::ACC_WIDTH_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  input  logic signed [DATA_W-1:0]          dividend_i,
  input  logic [gpool_pkg::WIN_W-1:0]       divisor_i,
  input  gpool_pkg::tag_t                   tag_i,
  output logic                              busy_o,
  output logic                              done_o,
  input  logic                              take_i,
  output logic signed [DATA_W-1:0]          quotient_o,
  output gpool_pkg::tag_t                   tag_o
);
  import gpool_pkg::*;

  localparam int unsigned CW = $clog2(DATA_W + 1);

  logic              run_q;
  logic              done_q;
  logic [CW-1:0]     cnt_q;
  logic [DATA_W-1:0] q_q;
  logic [WIN_W-1:0]  rem_q;
  logic [WIN_W-1:0]  div_q;
  logic              neg_q;
  tag_t              tag_q;

  logic [WIN_W:0]    trial;
  logic              bit_set;
  logic [WIN_W:0]    trial_sub;

  always_comb begin
    trial     = {rem_q, q_q[DATA_W-1]};
    bit_set   = (trial >= {1'b0, div_q});
    trial_sub = trial - {1'b0, div_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      if (start_i) begin
        run_q <= 1'b1;
        cnt_q <= CW'(DATA_W);
      end else if (run_q) begin
        cnt_q <= cnt_q - CW'(1);
        if (cnt_q == CW'(1)) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end else if (take_i) begin
        done_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      neg_q <= dividend_i[DATA_W-1];
      q_q   <= dividend_i[DATA_W-1] ? DATA_W'(-dividend_i) : DATA_W'(dividend_i);
      rem_q <= '0;
      div_q <= divisor_i;
      tag_q <= tag_i;
    end else if (run_q) begin
      rem_q <= bit_set ? trial_sub[WIN_W-1:0] : trial[WIN_W-1:0];
      q_q   <= {q_q[DATA_W-2:0], bit_set};
    end
  end

  assign busy_o     = run_q || done_q;
  assign done_o     = done_q;
  assign quotient_o = neg_q ? -$signed(q_q) : $signed(q_q);
  assign tag_o      = tag_q;

endmodule

FILE: test/pool_result_checker.sv
// Checker of the global pooling block: follows the configuration writes and the
// sample beats, predicts every pooled result and compares it with the output.
// Depends on gpool_pkg for the register indexes, the mode encoding and the widths.
`timescale 1ns / 1ps

module pool_result_checker (
  input  logic                                            clk_i,
  input  logic                                            rst_ni,
  input  logic                                            cfg_we_i,
  input  logic [gpool_pkg::CFG_IDX_W-1:0]                 cfg_idx_i,
  input  logic [gpool_pkg::CFG_DATA_W-1:0]                cfg_wdata_i,
  input  logic                                            s_tvalid_i,
  input  logic                                            s_tready_i,
  // sample
  input  logic [((gpool_pkg::SAMPLE_WIDTH_DEF+7)/8)*8-1:0] s_tdata_i,
  input  logic                                            m_tvalid_i,
  input  logic                                            m_tready_i,
  // pooled_value [15:0], channel_index [21:16], zero pad [23:22]
  input  logic [gpool_pkg::M_TDATA_W-1:0]                 m_tdata_i,
  input  logic                                            m_tlast_i,
  output int                                              errors_o,
  output int                                              pending_o,
  output int                                              results_o
);
  import gpool_pkg::*;

  typedef struct packed {
    logic signed [POOLED_W-1:0] value;
    logic [CH_IDX_W-1:0]        channel;
    logic                       last;
  } pooled_t;

  pool_mode_e            mode_q   = MODE_MAX;
  logic [COUNT_W-1:0]    count_q  = 7'd1;
  logic [WIN_W-1:0]      win_q    = 16'd1;
  logic [MARGIN_W-1:0]   margin_q = 4'd0;

  logic signed [ACC_WIDTH_DEF-1:0] acc_mem [MAX_CHANNELS_DEF];
  int unsigned chan_ctr = 0;
  int unsigned pos_ctr  = 0;
  pooled_t     expected_pool_q[$];
  int          errors  = 0;
  int          results = 0;

  // Folds one sample into its channel and queues the pooled value when the
  // sample belongs to the last position of the window.
  task automatic pool_sample(input logic [7:0] raw);
    int unsigned cnt, win, ch, e;
    longint      x, acc, hi, lo, avg;
    bit          first_pos, last_pos, last_ch;
    pooled_t     r;
    cnt = count_q;
    if (cnt == 0) cnt = 1;
    if (cnt > MAX_CHANNELS_DEF) cnt = MAX_CHANNELS_DEF;
    win = win_q;
    if (win == 0) win = 1;
    if (chan_ctr >= cnt) chan_ctr = 0;
    x = $signed(raw);
    ch = chan_ctr;
    first_pos = (pos_ctr == 0);
    last_pos  = (pos_ctr >= win - 1);
    last_ch   = (ch >= cnt - 1);
    if (first_pos) acc = 0;
    else acc = acc_mem[ch];
    if (mode_q == MODE_MAX) begin
      if (first_pos || x > acc) acc = x;
    end else begin
      e = SAMPLE_WIDTH_DEF + margin_q - 1;
      if (e > ACC_WIDTH_DEF - 1) e = ACC_WIDTH_DEF - 1;
      hi = (longint'(1) << e) - 1;
      lo = -(longint'(1) << e);
      acc = acc + x;
      if (acc > hi) acc = hi;
      else if (acc < lo) acc = lo;
    end
    acc_mem[ch] = acc[ACC_WIDTH_DEF-1:0];
    if (last_ch) begin
      chan_ctr = 0;
      pos_ctr  = last_pos ? 0 : pos_ctr + 1;
    end else begin
      chan_ctr = ch + 1;
    end
    if (last_pos) begin
      avg = acc / longint'(win);
      r.value   = (mode_q == MODE_MAX) ? acc[POOLED_W-1:0] : avg[POOLED_W-1:0];
      r.channel = ch[CH_IDX_W-1:0];
      r.last    = last_ch;
      expected_pool_q.push_back(r);
    end
  endtask

  always @(posedge clk_i) begin
    pooled_t want, got;
    if (!rst_ni) begin
      mode_q   = MODE_MAX;
      count_q  = 7'd1;
      win_q    = 16'd1;
      margin_q = 4'd0;
      chan_ctr = 0;
      pos_ctr  = 0;
      for (int i = 0; i < MAX_CHANNELS_DEF; i++) acc_mem[i] = '0;
    end else begin
      if (m_tvalid_i && m_tready_i) begin
        got.value   = $signed(m_tdata_i[POOLED_W-1:0]);
        got.channel = m_tdata_i[POOLED_W +: CH_IDX_W];
        got.last    = m_tlast_i;
        results++;
        if (expected_pool_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected result beat, expected none, got value %0d ch %0d last %0b",
                   $time, got.value, got.channel, got.last);
        end else begin
          want = expected_pool_q.pop_front();
          if (got !== want) begin
            errors++;
            $display("%0t: result mismatch, expected value %0d ch %0d last %0b, got value %0d ch %0d last %0b",
                     $time, want.value, want.channel, want.last,
                     got.value, got.channel, got.last);
          end
        end
      end
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_idx_i))
          CFG_POOL_MODE:        mode_q   = pool_mode_e'(cfg_wdata_i[0]);
          CFG_CHANNEL_COUNT:    count_q  = cfg_wdata_i[COUNT_W-1:0];
          CFG_WINDOW_POSITIONS: win_q    = cfg_wdata_i[WIN_W-1:0];
          CFG_MARGIN_BITS:      margin_q = cfg_wdata_i[MARGIN_W-1:0];
          default: ;
        endcase
      end
      if (s_tvalid_i && s_tready_i) pool_sample(s_tdata_i[7:0]);
    end
    errors_o  = errors;
    pending_o = expected_pool_q.size();
    results_o = results;
  end

endmodule

FILE: test/testbench.sv
// Top of the global pooling testbench: clock, reset, configuration writes,
// sample stimulus under varying flow control, watchdog and verdict.
// Depends on gpool_pkg, global_pool_max_or_avg and pool_result_checker.
`timescale 1ns / 1ps

module testbench;
  import gpool_pkg::*;

  localparam int CYCLE_LIMIT  = 5000;
  localparam int DRAIN_CYCLES = 40;
  localparam int RANDOM_ITEMS = 550;

  logic                    clk_i         = 1'b0;
  logic                    rst_ni        = 1'b0;
  logic                    cfg_we_i      = 1'b0;
  logic [CFG_IDX_W-1:0]    cfg_idx_i     = '0;
  logic [CFG_DATA_W-1:0]   cfg_wdata_i   = '0;
  logic                    s_axis_tvalid = 1'b0;
  logic                    s_axis_tready;
  logic [7:0]              s_axis_tdata  = '0;
  logic                    m_axis_tvalid;
  logic                    m_axis_tready = 1'b0;
  logic [M_TDATA_W-1:0]    m_axis_tdata;
  logic                    m_axis_tlast;

  int errors, pending, results;
  int idle_pct   = 0;
  int stall_pct  = 0;
  int quiet      = 0;
  int beats_sent = 0;
  int settings   = 0;

  global_pool_max_or_avg dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  pool_result_checker pool_chk (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .s_tvalid_i  (s_axis_tvalid),
    .s_tready_i  (s_axis_tready),
    .s_tdata_i   (s_axis_tdata),
    .m_tvalid_i  (m_axis_tvalid),
    .m_tready_i  (m_axis_tready),
    .m_tdata_i   (m_axis_tdata),
    .m_tlast_i   (m_axis_tlast),
    .errors_o    (errors),
    .pending_o   (pending),
    .results_o   (results)
  );

  always #5 clk_i = ~clk_i;

  always @(negedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= stall_pct);
  end

  // Any accepted beat or register write counts as progress.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_we_i)
      quiet = 0;
    else
      quiet++;
    if (quiet >= CYCLE_LIMIT) begin
      $display("%0t: no beat accepted for %0d cycles", $time, CYCLE_LIMIT);
      $display("FAIL global_pool_max_or_avg");
      $finish;
    end
  end

  task automatic write_reg(input cfg_idx_e idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we_i    = 1'b1;
    cfg_idx_i   = idx;
    cfg_wdata_i = val;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  task automatic configure_pool(input pool_mode_e mode, input int unsigned cnt,
                                input int unsigned win, input int unsigned margin);
    write_reg(CFG_POOL_MODE, CFG_DATA_W'(mode));
    write_reg(CFG_CHANNEL_COUNT, CFG_DATA_W'(cnt));
    write_reg(CFG_WINDOW_POSITIONS, CFG_DATA_W'(win));
    write_reg(CFG_MARGIN_BITS, CFG_DATA_W'(margin));
    settings++;
  endtask

  task automatic send_sample(input logic [7:0] v);
    while ($urandom_range(99) < idle_pct) begin
      s_axis_tvalid = 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = v;
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
    beats_sent++;
  endtask

  // Waits for every predicted result, then lets the divider run out.
  task automatic drain();
    s_axis_tvalid = 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  task automatic set_flow(input int k);
    case (k % 4)
      0: begin idle_pct = 0;  stall_pct = 0;  end
      1: begin idle_pct = 76; stall_pct = 0;  end
      2: begin idle_pct = 0;  stall_pct = 76; end
      default: begin idle_pct = 35; stall_pct = 35; end
    endcase
  endtask

  function automatic logic [7:0] random_sample();
    if ($urandom_range(7) == 0) return $urandom_range(1) ? 8'h7f : 8'h80;
    return 8'($urandom_range(255));
  endfunction

  initial begin
    int          phase, random_sent, k, n_items, eff;
    int unsigned cnt, win, margin;
    pool_mode_e  mode;
    phase = 0;
    random_sent = 0;
    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Reset configuration: max mode, one channel, one position.
    send_sample(8'h80);
    send_sample(8'h7f);
    send_sample(8'h00);
    send_sample(8'hff);
    send_sample(8'h55);
    send_sample(8'haa);
    drain();

    // Average with no margin: sums saturate at once, odd negatives truncate.
    configure_pool(MODE_AVG, 2, 2, 0);
    send_sample(8'h7f);
    send_sample(8'h80);
    send_sample(8'h7f);
    send_sample(8'h80);
    send_sample(8'hfd);
    send_sample(8'h05);
    send_sample(8'h00);
    send_sample(8'h00);
    drain();

    // Zero channel count and zero window both act as one.
    configure_pool(MODE_MAX, 0, 0, 0);
    send_sample(8'h80);
    send_sample(8'h01);
    drain();
    configure_pool(MODE_AVG, 1, 0, 8);
    send_sample(8'h81);
    send_sample(8'h7f);
    drain();

    while (random_sent < RANDOM_ITEMS) begin
      set_flow(phase);
      mode   = pool_mode_e'($urandom_range(1));
      margin = $urandom_range(0, 8);
      if (phase == 1) begin
        // Stop inside a huge window, then shrink channel count and window so
        // the counters sit past the new limits.
        configure_pool(mode, 3, 65535, margin);
        k = $urandom_range(2, 6);
        repeat (3 * k + 2) begin
          send_sample(random_sample());
          random_sent++;
        end
        drain();
        write_reg(CFG_CHANNEL_COUNT, CFG_DATA_W'(2));
        write_reg(CFG_WINDOW_POSITIONS, CFG_DATA_W'(2));
        repeat (10) begin
          send_sample(random_sample());
          random_sent++;
        end
      end else begin
        case (phase % 6)
          0: begin cnt = 64; win = $urandom_range(1, 2); end
          2: begin cnt = 100; win = 1; end
          3: begin cnt = $urandom_range(2, 9); win = $urandom_range(1, 6); end
          4: begin cnt = $urandom_range(1, 4); win = $urandom_range(2, 6); margin = 0; end
          5: begin cnt = $urandom_range(1, 6); win = $urandom_range(1, 5); margin = 8; end
          default: begin cnt = 1; win = $urandom_range(1, 8); end
        endcase
        configure_pool(mode, cnt, win, margin);
        eff = (cnt > MAX_CHANNELS_DEF) ? MAX_CHANNELS_DEF : cnt;
        n_items = 60 / (eff * win);
        if (n_items < 1) n_items = 1;
        n_items = n_items * eff * win;
        repeat (n_items) begin
          if ($urandom_range(63) == 0) begin
            s_axis_tvalid = 1'b0;
            while (pending != 0) @(negedge clk_i);
          end
          send_sample(random_sample());
          random_sent++;
        end
      end
      drain();
      phase++;
    end

    $display("Sent %0d sample beats and checked %0d pooled results under %0d settings,",
             beats_sent, results, settings);
    $display("in max and average mode with free, sender-idle, receiver-stall and mixed flow.");
    if (errors == 0)
      $display("PASS global_pool_max_or_avg");
    else
      $display("FAIL global_pool_max_or_avg");
    $finish;
  end

endmodule
